// ===== hw/rtl/wfe_pkg.sv =====
// Shared types and constants of the WS2812 frame encoder.
package wfe_pkg;

	localparam int ColorW   = 8;
	localparam int DutyW    = 16;
	localparam int ProductW = 16;
	localparam int PosW     = 13;
	localparam int BitsPerLed = 24;

	typedef enum logic [1:0] {
		OP_SET_PIXEL = 2'd0,
		OP_CLEAR     = 2'd1,
		OP_START     = 2'd2,
		OP_TICK      = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		CFG_BRIGHTNESS = 2'd0,
		CFG_DUTY_ONE   = 2'd1,
		CFG_DUTY_ZERO  = 2'd2,
		CFG_LATCH      = 2'd3
	} cfg_index_t;

	typedef struct packed {
		logic                start;
		logic [ProductW-1:0] dividend;
	} div_req_t;

endpackage

// ===== hw/rtl/wfe_ram.sv =====
// Generic single write port RAM with one registered read port.
module wfe_ram #(
	parameter  int WIDTH = 24,
	parameter  int DEPTH = 64,
	localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AddrW-1:0]     waddr,
	input  logic [WIDTH-1:0]     wdata,
	input  logic                 re,
	input  logic [AddrW-1:0]     raddr,
	output logic [WIDTH-1:0]     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/wfe_div.sv =====
// Divider by a constant through a reciprocal multiplication, quotient saturated to one byte.
module wfe_div #(
	parameter int DIVISOR = 255
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  wfe_pkg::div_req_t            req,
	output logic                         done,
	output logic [wfe_pkg::ColorW-1:0]   quotient
);

	localparam int DvdW   = wfe_pkg::ProductW;
	localparam int RoundW = (DIVISOR > 1) ? $clog2(DIVISOR) : 0;
	localparam int Shift  = DvdW + RoundW;
	localparam int RecipW = DvdW + 2;
	localparam longint RecipL =
		((longint'(1) << Shift) + longint'(DIVISOR) - longint'(1)) / longint'(DIVISOR);
	localparam logic [RecipW-1:0] Recip = RecipW'(RecipL);
	localparam int ProdW  = DvdW + RecipW;
	localparam int QuotW  = ProdW - Shift;

	logic [DvdW-1:0]  dvd_q;
	logic [ProdW-1:0] prod_q;
	logic             mul_q;
	logic             done_q;
	logic [QuotW-1:0] quot_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			mul_q  <= req.start;
			done_q <= mul_q;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
		end
		if (mul_q) begin
			prod_q <= ProdW'(dvd_q) * ProdW'(Recip);
		end
	end

	assign quot_full = prod_q[ProdW-1:Shift];
	assign done      = done_q;
	assign quotient  = (|quot_full[QuotW-1:wfe_pkg::ColorW]) ? '1 :
		quot_full[wfe_pkg::ColorW-1:0];

endmodule

// ===== hw/rtl/ws2812_frame_encoder.sv =====
// Top level of the WS2812 frame encoder that turns a pixel store into timer duty words.
//
// The block holds one GRB colour per LED in a RAM and, once a frame is started, answers
// each slot tick with one duty word: duty_one or duty_zero for every data bit, MSB first,
// of each colour byte scaled by brightness_level / FULL_SCALE, then latch_slots zero words,
// the final one flagged by frame_last. Commands are taken only while no tick is in progress.
// A tick in a latch slot goes straight to the emit state; a tick in a data slot first passes
// through the RAM read, the operand register and the multiply by the reciprocal of FULL_SCALE.
// A tick also waits while the previous result is still held in the output register.
// Clear takes effect at once through a per-LED valid bit, so no clearing pass is needed.
module ws2812_frame_encoder #(
	parameter int LED_COUNT  = 64,
	parameter int FULL_SCALE = 255,
	parameter int MIN_LEVEL  = 0
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [7:0]  led_index,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] duty_word,
	output logic        frame_last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int LedW      = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
	localparam int DataSlots = LED_COUNT * wfe_pkg::BitsPerLed;
	localparam int PixW      = 3 * wfe_pkg::ColorW;
	localparam logic [7:0] MinLevel = 8'(MIN_LEVEL);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RD,
		ST_DIV,
		ST_EMIT
	} state_t;

	state_t state_q;

	logic [7:0]                brightness_q;
	logic [15:0]               duty_one_q;
	logic [15:0]               duty_zero_q;
	logic [7:0]                latch_slots_q;

	logic                      armed_q;
	logic [wfe_pkg::PosW-1:0]  pos_q;
	logic [LedW-1:0]           led_q;
	logic [1:0]                byte_q;
	logic [2:0]                bit_q;
	logic [LED_COUNT-1:0]      pix_vld_q;

	logic [1:0]                tick_byte_q;
	logic [2:0]                tick_bit_q;
	logic                      tick_last_q;
	logic                      tick_data_q;
	logic                      tick_pix_ok_q;
	logic                      bit_val_q;

	logic                      out_valid_q;
	logic [15:0]               duty_word_q;
	logic                      frame_last_q;

	wfe_pkg::opcode_t          op;
	logic                      in_accept;
	logic                      set_ok;
	logic                      is_data;
	logic                      is_last;
	logic [wfe_pkg::PosW:0]    pos_next;
	logic [wfe_pkg::PosW:0]    total;
	logic [PixW-1:0]           rd_data;
	logic [PixW-1:0]           pixel;
	logic [7:0]                color;
	wfe_pkg::div_req_t         div_req;
	logic                      div_done;
	logic [7:0]                div_quot;
	logic                      out_free;
	logic [15:0]               duty_d;

	assign op        = wfe_pkg::opcode_t'(opcode);
	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign set_ok    = ({1'b0, led_index} < 9'(LED_COUNT));
	assign is_data   = (pos_q < wfe_pkg::PosW'(DataSlots));
	assign pos_next  = {1'b0, pos_q} + 14'd1;
	assign total     = 14'(DataSlots) + {6'd0, latch_slots_q};
	assign is_last   = (pos_next >= total);
	assign out_free  = !out_valid_q || !out_stall;

	wfe_ram #(
		.WIDTH(PixW),
		.DEPTH(LED_COUNT)
	) u_ram (
		.clk  (clk),
		.we   (in_accept && op == wfe_pkg::OP_SET_PIXEL && set_ok),
		.waddr(led_index[LedW-1:0]),
		.wdata({green, red, blue}),
		.re   (in_accept && op == wfe_pkg::OP_TICK),
		.raddr(led_q),
		.rdata(rd_data)
	);

	always_comb begin
		pixel = tick_pix_ok_q ? rd_data : '0;
		case (tick_byte_q)
			2'd0:    color = pixel[23:16];
			2'd1:    color = pixel[15:8];
			2'd2:    color = pixel[7:0];
			default: color = '0;
		endcase
		div_req.start    = (state_q == ST_RD);
		div_req.dividend = {8'd0, color} * {8'd0, brightness_q};
	end

	wfe_div #(
		.DIVISOR(FULL_SCALE)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (div_req),
		.done    (div_done),
		.quotient(div_quot)
	);

	assign duty_d = !tick_data_q ? 16'd0 : (bit_val_q ? duty_one_q : duty_zero_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q  <= 8'd255;
			duty_one_q    <= '0;
			duty_zero_q   <= '0;
			latch_slots_q <= 8'd50;
		end else if (cfg_valid && cfg_ready) begin
			unique case (wfe_pkg::cfg_index_t'(cfg_index))
				wfe_pkg::CFG_BRIGHTNESS:
					brightness_q <= (cfg_data[7:0] < MinLevel) ? MinLevel : cfg_data[7:0];
				wfe_pkg::CFG_DUTY_ONE:  duty_one_q    <= cfg_data;
				wfe_pkg::CFG_DUTY_ZERO: duty_zero_q   <= cfg_data;
				wfe_pkg::CFG_LATCH:     latch_slots_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			armed_q       <= 1'b0;
			pos_q         <= '0;
			led_q         <= '0;
			byte_q        <= '0;
			bit_q         <= '0;
			pix_vld_q     <= '0;
			tick_byte_q   <= '0;
			tick_bit_q    <= '0;
			tick_last_q   <= 1'b0;
			tick_data_q   <= 1'b0;
			tick_pix_ok_q <= 1'b0;
			bit_val_q     <= 1'b0;
			out_valid_q   <= 1'b0;
			duty_word_q   <= '0;
			frame_last_q  <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != ST_EMIT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						unique case (op)
							wfe_pkg::OP_SET_PIXEL: begin
								if (set_ok) begin
									pix_vld_q[led_index[LedW-1:0]] <= 1'b1;
								end
							end
							wfe_pkg::OP_CLEAR: begin
								pix_vld_q <= '0;
							end
							wfe_pkg::OP_START: begin
								armed_q <= 1'b1;
								pos_q   <= '0;
								led_q   <= '0;
								byte_q  <= '0;
								bit_q   <= '0;
							end
							wfe_pkg::OP_TICK: begin
								if (armed_q) begin
									tick_byte_q   <= byte_q;
									tick_bit_q    <= bit_q;
									tick_last_q   <= is_last;
									tick_data_q   <= is_data;
									tick_pix_ok_q <= pix_vld_q[led_q];
									state_q       <= is_data ? ST_RD : ST_EMIT;
									if (is_last) begin
										armed_q <= 1'b0;
										pos_q   <= '0;
										led_q   <= '0;
										byte_q  <= '0;
										bit_q   <= '0;
									end else begin
										pos_q <= pos_next[wfe_pkg::PosW-1:0];
										if (is_data) begin
											bit_q <= bit_q + 3'd1;
											if (bit_q == 3'd7) begin
												if (byte_q == 2'd2) begin
													byte_q <= '0;
													led_q  <= led_q + LedW'(1);
												end else begin
													byte_q <= byte_q + 2'd1;
												end
											end
										end
									end
								end
							end
							default: ;
						endcase
					end
				end
				ST_RD: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						bit_val_q <= div_quot[3'd7 - tick_bit_q];
						state_q   <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						duty_word_q  <= duty_d;
						frame_last_q <= tick_last_q;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign duty_word  = duty_word_q;
	assign frame_last = frame_last_q;

`ifndef ASSERT_OFF
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide state");

	a_led_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(armed_q && is_data) |-> ({1'b0, led_q} < (LedW + 1)'(LED_COUNT)))
		else $error("LED counter beyond LED count in a data slot");

	a_pos_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(armed_q && is_data) |->
		(pos_q == wfe_pkg::PosW'(led_q * 24 + byte_q * 8 + bit_q)))
		else $error("slot position disagrees with LED, byte and bit counters");

	a_rd_after_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD) |-> $past(in_accept && op == wfe_pkg::OP_TICK))
		else $error("pixel read without an accepted slot tick");
`endif

endmodule
